/* rtl/cso_pkg.sv */
`timescale 1ns / 1ps

package cso_pkg;

   // Frame size registers are fixed at 14 bits, up to 16383 pixels.
   localparam int DIM_BITS = 14;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TEXT_RED     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TEXT_GREEN   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TEXT_BLUE    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TEXT_ALPHA   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd5;

   localparam int COLOR_RESET  = 255;
   localparam int WIDTH_RESET  = 1920;
   localparam int HEIGHT_RESET = 1080;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic room;    // queue can take a beat
      logic valid;   // queue head holds a beat
   } cso_queue_stat_type;

endpackage

/* rtl/cso_req_if.sv */
`timescale 1ns / 1ps

interface cso_req_if #(
   parameter int CHANNEL_BITS = 8,
   parameter int COORD_BITS   = 15
) ();
   logic                           valid;
   logic                           ready;
   logic signed [COORD_BITS-1:0]   pixel_x;
   logic signed [COORD_BITS-1:0]   pixel_y;
   logic        [CHANNEL_BITS-1:0] coverage;
   logic        [CHANNEL_BITS-1:0] dest_red;
   logic        [CHANNEL_BITS-1:0] dest_green;
   logic        [CHANNEL_BITS-1:0] dest_blue;
   logic        [CHANNEL_BITS-1:0] dest_alpha;

   modport source (
      output valid, pixel_x, pixel_y, coverage, dest_red, dest_green, dest_blue,
             dest_alpha,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, coverage, dest_red, dest_green, dest_blue,
             dest_alpha,
      output ready
   );
endinterface

/* rtl/cso_rsp_if.sv */
`timescale 1ns / 1ps

interface cso_rsp_if #(
   parameter int CHANNEL_BITS = 8
) ();
   logic                    valid;
   logic                    ready;
   logic                    write_enable;
   logic [CHANNEL_BITS-1:0] out_red;
   logic [CHANNEL_BITS-1:0] out_green;
   logic [CHANNEL_BITS-1:0] out_blue;
   logic [CHANNEL_BITS-1:0] out_alpha;

   modport source (
      output valid, write_enable, out_red, out_green, out_blue, out_alpha,
      input  ready
   );

   modport sink (
      input  valid, write_enable, out_red, out_green, out_blue, out_alpha,
      output ready
   );
endinterface

/* rtl/coverage_source_over_blend.sv */
`timescale 1ns / 1ps

// Text blend unit: blends the text color into one destination pixel per beat,
// with the text alpha scaled by glyph coverage (source-over).
// req_ch carries position, coverage and destination RGBA; rsp_ch returns one
// beat per request, in order, with write_enable and the blended RGBA. When
// write_enable is low (zero coverage or off frame) the color equals the
// destination that came in.
// csr_* writes the text color and frame size; write only while no beat is in
// flight. Unknown indexes are dropped.
// Throughput: one beat per cycle while rsp_ch does not stall. A request passes
// the front register, a 4-entry queue and a 6-stage multiply / divide-by-M
// pipeline on its way to the response.
// A stalled rsp_ch freezes the back pipeline; the front keeps accepting until
// the queue fills, then drops req_ch.ready.
// Reset (synchronous, active high) empties all stages and restores the
// registers to white, fully opaque text on a 1920 x 1080 frame.
module coverage_source_over_blend #(
   parameter  int CHANNEL_BITS  = 8,
   parameter  int COORD_BITS    = 15,
   localparam int CSR_DATA_BITS = (CHANNEL_BITS > cso_pkg::DIM_BITS) ?
                                  CHANNEL_BITS : cso_pkg::DIM_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   cso_req_if.sink                            req_ch,
   cso_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [cso_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]           csr_data
);
   import cso_pkg::*;

   localparam int ITEM_BITS = 1 + 6 * CHANNEL_BITS;

   logic [CHANNEL_BITS-1:0] text_red;
   logic [CHANNEL_BITS-1:0] text_green;
   logic [CHANNEL_BITS-1:0] text_blue;
   logic [CHANNEL_BITS-1:0] text_alpha;
   logic [DIM_BITS-1:0]     frame_width;
   logic [DIM_BITS-1:0]     frame_height;
   cso_queue_stat_type      q_stat;
   logic                    push;
   logic                    pop;
   logic [ITEM_BITS-1:0]    front_item;
   logic [ITEM_BITS-1:0]    head_item;

   cso_csr #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .DATA_BITS    (CSR_DATA_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .text_red     (text_red),
      .text_green   (text_green),
      .text_blue    (text_blue),
      .text_alpha   (text_alpha),
      .frame_width  (frame_width),
      .frame_height (frame_height)
   );

   cso_front #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .COORD_BITS   (COORD_BITS),
      .ITEM_BITS    (ITEM_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .text_alpha   (text_alpha),
      .frame_width  (frame_width),
      .frame_height (frame_height),
      .q_stat       (q_stat),
      .push         (push),
      .item         (front_item)
   );

   cso_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .data_in  (front_item),
      .pop      (pop),
      .stat     (q_stat),
      .data_out (head_item)
   );

   cso_back #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .ITEM_BITS    (ITEM_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .head       (head_item),
      .pop        (pop),
      .text_red   (text_red),
      .text_green (text_green),
      .text_blue  (text_blue),
      .rsp        (rsp_ch)
   );

endmodule

/* rtl/cso_csr.sv */
`timescale 1ns / 1ps

module cso_csr #(
   parameter int CHANNEL_BITS = 8,
   parameter int DATA_BITS    = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [cso_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DATA_BITS-1:0]              csr_data,
   output logic [CHANNEL_BITS-1:0]           text_red,
   output logic [CHANNEL_BITS-1:0]           text_green,
   output logic [CHANNEL_BITS-1:0]           text_blue,
   output logic [CHANNEL_BITS-1:0]           text_alpha,
   output logic [cso_pkg::DIM_BITS-1:0]      frame_width,
   output logic [cso_pkg::DIM_BITS-1:0]      frame_height
);
   import cso_pkg::*;

   logic [CHANNEL_BITS-1:0] text_red_ff;
   logic [CHANNEL_BITS-1:0] text_green_ff;
   logic [CHANNEL_BITS-1:0] text_blue_ff;
   logic [CHANNEL_BITS-1:0] text_alpha_ff;
   logic [DIM_BITS-1:0]     frame_width_ff;
   logic [DIM_BITS-1:0]     frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_red_ff     <= CHANNEL_BITS'(COLOR_RESET);
         text_green_ff   <= CHANNEL_BITS'(COLOR_RESET);
         text_blue_ff    <= CHANNEL_BITS'(COLOR_RESET);
         text_alpha_ff   <= CHANNEL_BITS'(COLOR_RESET);
         frame_width_ff  <= DIM_BITS'(WIDTH_RESET);
         frame_height_ff <= DIM_BITS'(HEIGHT_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TEXT_RED:     text_red_ff     <= csr_data[CHANNEL_BITS-1:0];
            REG_TEXT_GREEN:   text_green_ff   <= csr_data[CHANNEL_BITS-1:0];
            REG_TEXT_BLUE:    text_blue_ff    <= csr_data[CHANNEL_BITS-1:0];
            REG_TEXT_ALPHA:   text_alpha_ff   <= csr_data[CHANNEL_BITS-1:0];
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data[DIM_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign text_red     = text_red_ff;
   assign text_green   = text_green_ff;
   assign text_blue    = text_blue_ff;
   assign text_alpha   = text_alpha_ff;
   assign frame_width  = frame_width_ff;
   assign frame_height = frame_height_ff;

endmodule

/* rtl/cso_front.sv */
`timescale 1ns / 1ps

module cso_front #(
   parameter int CHANNEL_BITS = 8,
   parameter int COORD_BITS   = 15,
   parameter int ITEM_BITS    = 49
) (
   input  logic                            clock,
   input  logic                            reset,
   cso_req_if.sink                         req,
   input  logic [CHANNEL_BITS-1:0]         text_alpha,
   input  logic [cso_pkg::DIM_BITS-1:0]    frame_width,
   input  logic [cso_pkg::DIM_BITS-1:0]    frame_height,
   input  cso_pkg::cso_queue_stat_type     q_stat,
   output logic                            push,
   output logic [ITEM_BITS-1:0]            item
);
   import cso_pkg::*;

   localparam int CMP_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
   localparam int PROD_BITS = 2 * CHANNEL_BITS;

   logic                 valid_ff;
   logic                 valid_in;
   logic [ITEM_BITS-1:0] item_ff;
   logic [ITEM_BITS-1:0] item_in;
   logic                 fire;
   logic [CMP_BITS-1:0]  x_ext;
   logic [CMP_BITS-1:0]  y_ext;
   logic [CMP_BITS-1:0]  w_ext;
   logic [CMP_BITS-1:0]  h_ext;
   logic                 on_frame;
   logic                 write;
   logic [PROD_BITS-1:0] prod;

   assign req.ready = !valid_ff || q_stat.room;
   assign fire      = req.valid && req.ready;
   assign push      = valid_ff && q_stat.room;
   assign item      = item_ff;

   always_comb begin
      x_ext  = {{(CMP_BITS-COORD_BITS){1'b0}}, req.pixel_x};
      y_ext  = {{(CMP_BITS-COORD_BITS){1'b0}}, req.pixel_y};
      w_ext  = {{(CMP_BITS-DIM_BITS){1'b0}}, frame_width};
      h_ext  = {{(CMP_BITS-DIM_BITS){1'b0}}, frame_height};
      // sign bit set means off frame to the left or top
      on_frame = !req.pixel_x[COORD_BITS-1] && !req.pixel_y[COORD_BITS-1] &&
                 (x_ext < w_ext) && (y_ext < h_ext);
      write  = on_frame && (req.coverage != '0);
      prod   = PROD_BITS'(text_alpha) * PROD_BITS'(req.coverage);
      item_in = {write, prod, req.dest_red, req.dest_green, req.dest_blue,
                 req.dest_alpha};
      if (req.ready) begin
         valid_in = req.valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         item_ff <= item_in;
      end
   end

   // zero coverage never turns into a write
   a_zero_cov_no_write: assert property (@(posedge clock) disable iff (reset)
      (fire && (req.coverage == '0)) |=> !item_ff[ITEM_BITS-1])
      else $error("zero coverage classified as write");

endmodule

/* rtl/cso_queue.sv */
`timescale 1ns / 1ps

module cso_queue #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            data_in,
   input  logic                        pop,
   output cso_pkg::cso_queue_stat_type stat,
   output logic [WIDTH-1:0]            data_out
);
   import cso_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   assign stat.room  = count_ff < CNT_BITS'(DEPTH);
   assign stat.valid = count_ff != '0;
   assign data_out   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count beyond depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

endmodule

/* rtl/cso_back.sv */
`timescale 1ns / 1ps

module cso_back #(
   parameter int CHANNEL_BITS = 8,
   parameter int ITEM_BITS    = 49
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cso_pkg::cso_queue_stat_type q_stat,
   input  logic [ITEM_BITS-1:0]        head,
   output logic                        pop,
   input  logic [CHANNEL_BITS-1:0]     text_red,
   input  logic [CHANNEL_BITS-1:0]     text_green,
   input  logic [CHANNEL_BITS-1:0]     text_blue,
   cso_rsp_if.source                   rsp
);
   import cso_pkg::*;

   localparam int B      = CHANNEL_BITS;
   localparam int DW     = 3 * B + 2;
   localparam int FOLDS  = 4;
   localparam int STAGES = 6;
   localparam logic [B-1:0]  M_B    = {B{1'b1}};
   localparam logic [DW-1:0] M_DW   = {{(DW-B){1'b0}}, {B{1'b1}}};
   localparam logic [DW-1:0] HALF1  = M_DW >> 1;
   localparam logic [DW-1:0] HALF2  = (M_DW * M_DW) >> 1;

   // floor(y / (2^B - 1)): fold the high part back onto the low part,
   // since 2^B = M + 1, then one compare-subtract.
   function automatic logic [DW-1:0] div_m(input logic [DW-1:0] y);
      logic [DW-1:0] q;
      logic [DW-1:0] s;
      q = '0;
      s = y;
      for (int i = 0; i < FOLDS; i++) begin
         q = q + (s >> B);
         s = (s >> B) + (s & M_DW);
      end
      if (s >= M_DW) begin
         q = q + 1'b1;
      end
      return q;
   endfunction

   function automatic logic [DW-1:0] mul_m(input logic [DW-1:0] x);
      return (x << B) - x;
   endfunction

   logic                 advance;
   logic [STAGES-1:0]    valid_ff;
   logic [STAGES-1:0]    valid_in;
   logic [B-1:0]         color [3];

   // decoded queue head
   logic                 head_we;
   logic [2*B-1:0]       head_p;
   logic [B-1:0]         head_d [4];
   logic [DW-1:0]        q_a;
   logic [DW-1:0]        t_an;
   logic [DW-1:0]        q_an;
   logic [DW-1:0]        q_y [3];
   logic [DW-1:0]        q_r [3];

   // stage 1: effective alpha
   logic                 we1_ff, we1_in;
   logic [B-1:0]         a1_ff, a1_in;
   logic [B-1:0]         d1_ff [4];
   // stage 2: first products
   logic                 we2_ff;
   logic [B-1:0]         a2_ff;
   logic [B-1:0]         d2_ff [4];
   logic [2*B-1:0]       pa2_ff [3], pa2_in [3];
   logic [2*B-1:0]       pc2_ff [3], pc2_in [3];
   logic [2*B-1:0]       pl2_ff [3], pl2_in [3];
   logic [2*B-1:0]       pad2_ff, pad2_in;
   // stage 3: straight-color product, alpha numerator
   logic                 we3_ff;
   logic [B-1:0]         d3_ff [4];
   logic [2*B-1:0]       pa3_ff [3];
   logic [2*B-1:0]       pl3_ff [3];
   logic [3*B-1:0]       pcc3_ff [3], pcc3_in [3];
   logic [2*B:0]         anum3_ff, anum3_in;
   // stage 4: channel numerators, alpha done
   logic                 we4_ff;
   logic [B-1:0]         d4_ff [4];
   logic [DW-1:0]        n4_ff [3], n4_in [3];
   logic [B-1:0]         an4_ff, an4_in;
   // stage 5: first division by M
   logic                 we5_ff;
   logic [B-1:0]         d5_ff [4];
   logic [2*B-1:0]       y5_ff [3], y5_in [3];
   logic [B-1:0]         an5_ff;
   // stage 6: output register
   logic                 we6_ff;
   logic [B-1:0]         out6_ff [4], out6_in [4];

   assign color[0] = text_red;
   assign color[1] = text_green;
   assign color[2] = text_blue;

   assign advance  = !valid_ff[STAGES-1] || rsp.ready;
   assign pop      = advance && q_stat.valid;
   assign valid_in = {valid_ff[STAGES-2:0], q_stat.valid};

   always_comb begin
      head_we = head[ITEM_BITS-1];
      head_p  = head[ITEM_BITS-2 -: 2*B];
      for (int i = 0; i < 4; i++) begin
         head_d[i] = head[(4-i)*B-1 -: B];
      end
      q_a   = div_m(DW'(head_p) + HALF1);
      a1_in = (q_a > M_DW) ? M_B : q_a[B-1:0];
      we1_in = head_we;

      for (int i = 0; i < 3; i++) begin
         pa2_in[i] = (2*B)'(M_B - a1_ff) * (2*B)'(d1_ff[i]);
         pc2_in[i] = (2*B)'(color[i]) * (2*B)'(a1_ff);
         // a * min(1, c/a) == min(a, c)
         pl2_in[i] = (2*B)'(d1_ff[3]) *
                     (2*B)'((a1_ff < color[i]) ? a1_ff : color[i]);
      end
      pad2_in = (2*B)'(a1_ff) * (2*B)'(d1_ff[3]);

      for (int i = 0; i < 3; i++) begin
         pcc3_in[i] = (3*B)'(M_B - d2_ff[3]) * (3*B)'(pc2_ff[i]);
      end
      t_an     = mul_m(DW'(a2_ff)) + mul_m(DW'(d2_ff[3])) - DW'(pad2_ff) + HALF1;
      anum3_in = t_an[2*B:0];

      for (int i = 0; i < 3; i++) begin
         n4_in[i] = mul_m(DW'(pa3_ff[i])) + DW'(pcc3_ff[i]) +
                    mul_m(DW'(pl3_ff[i])) + HALF2;
      end
      q_an   = div_m(DW'(anum3_ff));
      an4_in = (q_an > M_DW) ? M_B : q_an[B-1:0];

      // rounding offset already in n, so two floors make the rounded quotient
      for (int i = 0; i < 3; i++) begin
         q_y[i]   = div_m(n4_ff[i]);
         y5_in[i] = q_y[i][2*B-1:0];
      end

      for (int i = 0; i < 3; i++) begin
         q_r[i] = div_m(DW'(y5_ff[i]));
         if (!we5_ff) begin
            out6_in[i] = d5_ff[i];
         end else if (q_r[i] > M_DW) begin
            out6_in[i] = M_B;
         end else begin
            out6_in[i] = q_r[i][B-1:0];
         end
      end
      out6_in[3] = we5_ff ? an5_ff : d5_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         we1_ff   <= we1_in;
         a1_ff    <= a1_in;
         we2_ff   <= we1_ff;
         a2_ff    <= a1_ff;
         pad2_ff  <= pad2_in;
         we3_ff   <= we2_ff;
         anum3_ff <= anum3_in;
         we4_ff   <= we3_ff;
         an4_ff   <= an4_in;
         we5_ff   <= we4_ff;
         an5_ff   <= an4_ff;
         we6_ff   <= we5_ff;
         for (int i = 0; i < 4; i++) begin
            d1_ff[i]   <= head_d[i];
            d2_ff[i]   <= d1_ff[i];
            d3_ff[i]   <= d2_ff[i];
            d4_ff[i]   <= d3_ff[i];
            d5_ff[i]   <= d4_ff[i];
            out6_ff[i] <= out6_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            pa2_ff[i]  <= pa2_in[i];
            pc2_ff[i]  <= pc2_in[i];
            pl2_ff[i]  <= pl2_in[i];
            pa3_ff[i]  <= pa2_ff[i];
            pl3_ff[i]  <= pl2_ff[i];
            pcc3_ff[i] <= pcc3_in[i];
            n4_ff[i]   <= n4_in[i];
            y5_ff[i]   <= y5_in[i];
         end
      end
   end

   assign rsp.valid        = valid_ff[STAGES-1];
   assign rsp.write_enable = we6_ff;
   assign rsp.out_red      = out6_ff[0];
   assign rsp.out_green    = out6_ff[1];
   assign rsp.out_blue     = out6_ff[2];
   assign rsp.out_alpha    = out6_ff[3];

   // source-over never lowers the destination alpha
   a_alpha_grows: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && we4_ff) |-> (an4_ff >= d4_ff[3]))
      else $error("blended alpha below destination alpha");

   a_frozen_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved while output stalled");

endmodule

/* verif/coverage_source_over_blend_tb.sv */
`timescale 1ns / 1ps

module coverage_source_over_blend_tb;

   localparam int CH = 8;
   localparam int CRD = 15;
   localparam int CSR_BITS = (CH > cso_pkg::DIM_BITS) ? CH : cso_pkg::DIM_BITS;

   // index past the register list, must be dropped by the block
   localparam logic [cso_pkg::CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd6;

   typedef struct packed {
      logic signed [CRD-1:0] x;
      logic signed [CRD-1:0] y;
      logic [CH-1:0]         cov;
      logic [CH-1:0]         dr;
      logic [CH-1:0]         dg;
      logic [CH-1:0]         db;
      logic [CH-1:0]         da;
   } pixel_in_type;

   typedef struct packed {
      logic          we;
      logic [CH-1:0] r;
      logic [CH-1:0] g;
      logic [CH-1:0] b;
      logic [CH-1:0] a;
   } blend_out_type;

   class blend_checker;
      logic [CH-1:0]                  text_r, text_g, text_b, text_a;
      logic [cso_pkg::DIM_BITS-1:0]   frame_w, frame_h;
      blend_out_type                  pending_px[$];
      int mismatches;
      int blends_checked;
      int writes_seen;

      function new();
         text_r = CH'(cso_pkg::COLOR_RESET);
         text_g = CH'(cso_pkg::COLOR_RESET);
         text_b = CH'(cso_pkg::COLOR_RESET);
         text_a = CH'(cso_pkg::COLOR_RESET);
         frame_w = (cso_pkg::DIM_BITS)'(cso_pkg::WIDTH_RESET);
         frame_h = (cso_pkg::DIM_BITS)'(cso_pkg::HEIGHT_RESET);
         mismatches = 0;
         blends_checked = 0;
         writes_seen = 0;
      endfunction

      function void set_reg(logic [cso_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [CSR_BITS-1:0] v);
         case (idx)
            cso_pkg::REG_TEXT_RED:     text_r = v[CH-1:0];
            cso_pkg::REG_TEXT_GREEN:   text_g = v[CH-1:0];
            cso_pkg::REG_TEXT_BLUE:    text_b = v[CH-1:0];
            cso_pkg::REG_TEXT_ALPHA:   text_a = v[CH-1:0];
            cso_pkg::REG_FRAME_WIDTH:  frame_w = v[cso_pkg::DIM_BITS-1:0];
            cso_pkg::REG_FRAME_HEIGHT: frame_h = v[cso_pkg::DIM_BITS-1:0];
            default: ;
         endcase
      endfunction

      // (M-a)*d*M + (M-da)*c*a + da*min(a,c)*M, over M^2, round half up
      function logic [CH-1:0] mix_channel(longint unsigned c, longint unsigned a,
                                          longint unsigned d, longint unsigned da);
         longint unsigned m;
         longint unsigned lo;
         longint unsigned num;
         longint unsigned q;
         m = (1 << CH) - 1;
         lo = (a < c) ? a : c;
         num = (m - a) * d * m + (m - da) * c * a + da * lo * m;
         q = (2 * num + m * m) / (2 * m * m);
         if (q > m) q = m;
         return q[CH-1:0];
      endfunction

      function blend_out_type blend_pixel(pixel_in_type p);
         blend_out_type   o;
         longint unsigned m;
         longint unsigned a;
         longint unsigned an;
         longint unsigned da;
         int              xi;
         int              yi;
         bit              on_frame;
         m = (1 << CH) - 1;
         xi = p.x;
         yi = p.y;
         on_frame = xi >= 0 && yi >= 0 && xi < int'(frame_w) && yi < int'(frame_h);
         o = '{we: 1'b0, r: p.dr, g: p.dg, b: p.db, a: p.da};
         if (p.cov == 0 || !on_frame) return o;
         a = (2 * longint'(text_a) * longint'(p.cov) + m) / (2 * m);
         if (a > m) a = m;
         da = p.da;
         an = (2 * (a * m + da * m - a * da) + m) / (2 * m);
         if (an > m) an = m;
         o.we = 1'b1;
         o.r = mix_channel(text_r, a, p.dr, da);
         o.g = mix_channel(text_g, a, p.dg, da);
         o.b = mix_channel(text_b, a, p.db, da);
         o.a = an[CH-1:0];
         return o;
      endfunction

      function void note_pixel(pixel_in_type p);
         pending_px = {pending_px, blend_pixel(p)};
      endfunction

      function void check_result(blend_out_type got);
         blend_out_type exp_px;
         if (pending_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result beat we=%0b rgba=%0d,%0d,%0d,%0d",
                        got.we, got.r, got.g, got.b, got.a);
            return;
         end
         exp_px = pending_px.pop_front();
         blends_checked++;
         if (got.we === 1'b1) writes_seen++;
         if (got.we !== exp_px.we || got.r !== exp_px.r || got.g !== exp_px.g ||
             got.b !== exp_px.b || got.a !== exp_px.a) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: beat %0d exp we=%0b %0d,%0d,%0d,%0d got we=%0b %0d,%0d,%0d,%0d",
                        blends_checked, exp_px.we, exp_px.r, exp_px.g, exp_px.b,
                        exp_px.a, got.we, got.r, got.g, got.b, got.a);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                               csr_we;
   logic [cso_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0]                csr_data;

   cso_req_if #(.CHANNEL_BITS(CH), .COORD_BITS(CRD)) req_ch ();
   cso_rsp_if #(.CHANNEL_BITS(CH)) rsp_ch ();

   coverage_source_over_blend #(.CHANNEL_BITS(CH), .COORD_BITS(CRD)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   blend_checker  board = new();
   int            req_idle_pct = 0;
   int            rsp_stall_pct = 0;
   int            hold_req = 0;
   int            hold_left = 0;
   int            settings_run = 0;
   blend_out_type rsp_beat;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         rsp_beat = '{we: rsp_ch.write_enable, r: rsp_ch.out_red, g: rsp_ch.out_green,
                      b: rsp_ch.out_blue, a: rsp_ch.out_alpha};
         board.check_result(rsp_beat);
      end
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic pixel_in_type px(int x, int y, int cov, int dr, int dg, int db,
                                       int da);
      pixel_in_type p;
      p.x = x[CRD-1:0];
      p.y = y[CRD-1:0];
      p.cov = cov[CH-1:0];
      p.dr = dr[CH-1:0];
      p.dg = dg[CH-1:0];
      p.db = db[CH-1:0];
      p.da = da[CH-1:0];
      return p;
   endfunction

   function automatic int pick_coord(int lim);
      int sel;
      sel = $urandom_range(99);
      if (sel < 70 && lim > 0) return $urandom_range(lim - 1, 0);
      if (sel < 85) begin
         case ($urandom_range(3))
            0: return lim - 1;
            1: return lim;
            2: return -1;
            default: return 0;
         endcase
      end
      return $urandom_range((1 << CRD) - 1) - (1 << (CRD - 1));
   endfunction

   function automatic int pick_level();
      case ($urandom_range(9))
         0: return 0;
         1: return (1 << CH) - 1;
         default: return $urandom_range((1 << CH) - 1);
      endcase
   endfunction

   function automatic pixel_in_type rand_pixel();
      return px(pick_coord(board.frame_w), pick_coord(board.frame_h), pick_level(),
                pick_level(), pick_level(), pick_level(), pick_level());
   endfunction

   task automatic send_pixel(input pixel_in_type p);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.pixel_x    <= p.x;
      req_ch.pixel_y    <= p.y;
      req_ch.coverage   <= p.cov;
      req_ch.dest_red   <= p.dr;
      req_ch.dest_green <= p.dg;
      req_ch.dest_blue  <= p.db;
      req_ch.dest_alpha <= p.da;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      board.note_pixel(p);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_px.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [cso_pkg::CSR_INDEX_BITS-1:0] idx, input int v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= v[CSR_BITS-1:0];
      board.set_reg(idx, v[CSR_BITS-1:0]);
      @(posedge clock);
   endtask

   task automatic load_setting(input int r, input int g, input int b, input int a,
                               input int w, input int h);
      wait_drained();
      write_reg(cso_pkg::REG_TEXT_RED, r);
      write_reg(cso_pkg::REG_TEXT_GREEN, g);
      write_reg(cso_pkg::REG_TEXT_BLUE, b);
      write_reg(cso_pkg::REG_TEXT_ALPHA, a);
      write_reg(cso_pkg::REG_FRAME_WIDTH, w);
      write_reg(cso_pkg::REG_FRAME_HEIGHT, h);
      csr_we <= 1'b0;
      settings_run++;
   endtask

   initial begin
      int ph;
      int n;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = cso_pkg::REG_TEXT_RED;
      csr_data          = '0;
      req_ch.valid      = 1'b0;
      req_ch.pixel_x    = '0;
      req_ch.pixel_y    = '0;
      req_ch.coverage   = '0;
      req_ch.dest_red   = '0;
      req_ch.dest_green = '0;
      req_ch.dest_blue  = '0;
      req_ch.dest_alpha = '0;
      rsp_ch.ready      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: white opaque text on 1920 x 1080
      send_pixel(px(0, 0, 255, 0, 0, 0, 0));
      send_pixel(px(1919, 1079, 255, 255, 255, 255, 255));
      send_pixel(px(1920, 0, 128, 10, 20, 30, 40));
      send_pixel(px(0, 1080, 128, 10, 20, 30, 40));
      send_pixel(px(-1, 5, 200, 1, 2, 3, 4));
      send_pixel(px(5, -1, 200, 1, 2, 3, 4));
      send_pixel(px(-16384, -16384, 255, 255, 0, 255, 0));
      send_pixel(px(16383, 16383, 255, 0, 255, 0, 255));
      send_pixel(px(100, 100, 0, 77, 88, 99, 111));
      send_pixel(px(100, 100, 1, 77, 88, 99, 111));
      send_pixel(px(1000, 500, 128, 200, 100, 50, 128));
      send_pixel(px(1000, 500, 255, 0, 0, 0, 255));

      // faint text: low coverage rounds the blend alpha to zero
      load_setting(200, 100, 50, 1, 1920, 1080);
      send_pixel(px(3, 4, 1, 12, 34, 56, 78));
      send_pixel(px(3, 4, 127, 12, 34, 56, 0));
      send_pixel(px(3, 4, 255, 12, 34, 56, 255));
      send_pixel(px(3, 4, 255, 255, 255, 255, 0));

      // out-of-list index is dropped; zero width or zero height makes every position off frame
      wait_drained();
      write_reg(REG_UNUSED, 16383);
      csr_we <= 1'b0;
      load_setting(90, 180, 30, 220, 0, 1080);
      send_pixel(px(0, 0, 255, 5, 6, 7, 8));
      send_pixel(px(10, 10, 100, 50, 60, 70, 80));
      load_setting(90, 180, 30, 220, 1920, 0);
      send_pixel(px(0, 0, 255, 5, 6, 7, 8));

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_setting($urandom_range(255), $urandom_range(255), $urandom_range(255),
                            $urandom_range(255), 1920, 1080);
            1: load_setting(0, 0, 0, 0, 1, 1);
            2: load_setting(255, 255, 255, 255, 16383, 16383);
            3: load_setting($urandom_range(255), $urandom_range(255), $urandom_range(255),
                            $urandom_range(255), 64, 32);
            4: load_setting($urandom_range(255), $urandom_range(255), $urandom_range(255),
                            $urandom_range(255), 0, 100);
            default: load_setting($urandom_range(255), $urandom_range(255),
                                  $urandom_range(255), $urandom_range(255), 640, 480);
         endcase
         req_idle_pct  = (ph < 2) ? 38 : (ph < 4) ? 56 : 0;
         rsp_stall_pct = (ph < 2) ? 56 : (ph < 4) ? 38 : 0;
         for (n = 0; n < 300; n++) begin
            // long output stall so the queue fills and req ready drops
            if (n == 100) hold_req = 150 + $urandom_range(100);
            if (n == 200) wait_drained();
            send_pixel(rand_pixel());
         end
      end

      wait_drained();
      repeat (12) @(posedge clock);
      $display("Checked %0d blended pixels (%0d written) across %0d color/frame settings,",
               board.blends_checked, board.writes_seen, settings_run);
      $display("including off-frame, zero-coverage, zero-frame and stalled-output traffic.");
      if (board.mismatches == 0 && board.pending_px.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending_px.size());
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding", board.pending_px.size());
      $display("Verification failed");
      $finish;
   end

endmodule
